// ----- rtl/core/pfc_pkg.sv -----
// Package for the prime factor count range query unit.
// It holds the shared constants and the query and result item types.
// It depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none
package pfc_pkg;

  localparam int unsigned MAX_N_DEFAULT = 65536;
  localparam int unsigned TOTAL_W = 20;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef struct packed {
    logic [15:0] upper;
    logic [15:0] lower;
  } pfc_query_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] factor_total;
    logic               bad_range;
  } pfc_result_t;

endpackage
`default_nettype wire

// ----- rtl/core/pfc_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// It depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none
module pfc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/pfc_builder.sv -----
// Table builder: clears a per-number factor count table, runs a prime-power
// sieve over it, then writes saturated prefix sums out to the query tables.
// It depends on pfc_pkg and pfc_ram.
`timescale 1ns / 1ps
`default_nettype none
module pfc_builder
  import pfc_pkg::*;
#(
  parameter int unsigned MAX_N = MAX_N_DEFAULT
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  output logic                          pre_we,
  output logic [$clog2(MAX_N)-1:0]      pre_addr,
  output logic [TOTAL_W-1:0]            pre_data,
  output logic                          ready
);

  localparam int unsigned AW = $clog2(MAX_N);
  localparam int unsigned CW = $clog2(AW + 1);
  localparam int unsigned PW = 2 * AW;

  typedef enum logic [3:0] {
    CLR, SCAN_RD, SCAN_CHK, ADD_RD, ADD_WR, POW_MUL, POW_CHK, PRE_RD, PRE_WR, DONE
  } state_t;

  state_t             state;
  logic [AW-1:0]      ctr;
  logic [AW-1:0]      num;
  logic [AW-1:0]      pw;
  logic [AW-1:0]      pos;
  logic [PW-1:0]      prod;
  logic [TOTAL_W-1:0] acc;

  logic               cnt_we;
  logic [AW-1:0]      cnt_waddr;
  logic [CW-1:0]      cnt_wdata;
  logic               cnt_re;
  logic [AW-1:0]      cnt_raddr;
  logic [CW-1:0]      cnt_rdata;

  logic [AW:0]        pos_step;
  logic [TOTAL_W-1:0] add_c;
  logic [TOTAL_W:0]   acc_sum;
  logic [TOTAL_W-1:0] acc_next;

  pfc_ram #(.WIDTH(CW), .DEPTH(MAX_N)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (cnt_re),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  // Count table port selection by state.
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = ctr;
    cnt_wdata = '0;
    cnt_re    = 1'b0;
    cnt_raddr = ctr;
    case (state)
      CLR: begin
        cnt_we = 1'b1;
      end
      SCAN_RD: begin
        cnt_re    = 1'b1;
        cnt_raddr = num;
      end
      ADD_RD: begin
        cnt_re    = 1'b1;
        cnt_raddr = pos;
      end
      ADD_WR: begin
        cnt_we    = 1'b1;
        cnt_waddr = pos;
        cnt_wdata = cnt_rdata + CW'(1);
      end
      PRE_RD: begin
        cnt_re = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Next multiple of the current prime power, and the saturating prefix sum.
  assign pos_step = {1'b0, pos} + {1'b0, pw};
  assign add_c    = (ctr < AW'(2)) ? '0 : TOTAL_W'(cnt_rdata);
  assign acc_sum  = {1'b0, acc} + {1'b0, add_c};
  assign acc_next = (acc > TOTAL_MAX - add_c) ? TOTAL_MAX : acc_sum[TOTAL_W-1:0];

  assign pre_we   = (state == PRE_WR);
  assign pre_addr = ctr;
  assign pre_data = acc_next;
  assign ready    = (state == DONE);

  // Build sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CLR;
      ctr   <= '0;
      num   <= AW'(2);
      acc   <= '0;
    end else begin
      case (state)
        CLR: begin
          ctr <= ctr + AW'(1);
          if (32'(ctr) == MAX_N - 1) begin
            num   <= AW'(2);
            state <= SCAN_RD;
          end
        end
        SCAN_RD: begin
          state <= SCAN_CHK;
        end
        SCAN_CHK: begin
          if (cnt_rdata == '0) begin
            pw    <= num;
            pos   <= num;
            state <= ADD_RD;
          end else if (32'(num) == MAX_N - 1) begin
            ctr   <= '0;
            acc   <= '0;
            state <= PRE_RD;
          end else begin
            num   <= num + AW'(1);
            state <= SCAN_RD;
          end
        end
        ADD_RD: begin
          state <= ADD_WR;
        end
        ADD_WR: begin
          if (32'(pos_step) < MAX_N) begin
            pos   <= pos_step[AW-1:0];
            state <= ADD_RD;
          end else begin
            state <= POW_MUL;
          end
        end
        POW_MUL: begin
          prod  <= PW'(pw) * PW'(num);
          state <= POW_CHK;
        end
        POW_CHK: begin
          if (prod < PW'(MAX_N)) begin
            pw    <= prod[AW-1:0];
            pos   <= prod[AW-1:0];
            state <= ADD_RD;
          end else if (32'(num) == MAX_N - 1) begin
            ctr   <= '0;
            acc   <= '0;
            state <= PRE_RD;
          end else begin
            num   <= num + AW'(1);
            state <= SCAN_RD;
          end
        end
        PRE_RD: begin
          state <= PRE_WR;
        end
        PRE_WR: begin
          acc <= acc_next;
          if (32'(ctr) == MAX_N - 1) begin
            state <= DONE;
          end else begin
            ctr   <= ctr + AW'(1);
            state <= PRE_RD;
          end
        end
        DONE: begin
        end
        default: begin
          state <= CLR;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/pfc_query.sv -----
// Query pipeline: two prefix table reads, then a subtraction into the
// result register. Depends on pfc_pkg and pfc_ram.
`timescale 1ns / 1ps
`default_nettype none
module pfc_query
  import pfc_pkg::*;
#(
  parameter int unsigned MAX_N = MAX_N_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 ready,
  input  wire logic                 pre_we,
  input  wire logic [$clog2(MAX_N)-1:0] pre_addr,
  input  wire logic [TOTAL_W-1:0]   pre_data,
  input  wire logic                 query_valid,
  output logic                      query_stall,
  input  wire pfc_query_t           query,
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output pfc_result_t               result
);

  localparam int unsigned AW = $clog2(MAX_N);

  logic               s1_valid;
  logic               s1_bad;
  logic [AW-1:0]      up_idx;
  logic [AW-1:0]      lo_idx;
  logic [TOTAL_W-1:0] up_sum;
  logic [TOTAL_W-1:0] lo_sum;
  logic               out_free;
  logic               accept;

  // Clamp both indexes to the top table entry.
  assign up_idx = (32'(query.upper) >= MAX_N) ? AW'(MAX_N - 1) : AW'(query.upper);
  assign lo_idx = (32'(query.lower) >= MAX_N) ? AW'(MAX_N - 1) : AW'(query.lower);

  assign out_free    = !result_valid || !result_stall;
  assign query_stall = !ready || (s1_valid && !out_free);
  assign accept      = query_valid && !query_stall;

  pfc_ram #(.WIDTH(TOTAL_W), .DEPTH(MAX_N)) u_up_ram (
    .clk(clk), .we(pre_we), .waddr(pre_addr), .wdata(pre_data),
    .re(accept), .raddr(up_idx), .rdata(up_sum)
  );

  pfc_ram #(.WIDTH(TOTAL_W), .DEPTH(MAX_N)) u_lo_ram (
    .clk(clk), .we(pre_we), .waddr(pre_addr), .wdata(pre_data),
    .re(accept), .raddr(lo_idx), .rdata(lo_sum)
  );

  // Read stage and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        s1_bad   <= lo_idx > up_idx;
      end else if (out_free) begin
        s1_valid <= 1'b0;
      end
      if (out_free) begin
        result_valid <= s1_valid;
        if (s1_valid) begin
          result.bad_range    <= s1_bad;
          result.factor_total <= s1_bad ? '0 : up_sum - lo_sum;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/prime_factor_count_range_query_unit.sv -----
// Prime factor count range query unit, top level. Depends on pfc_pkg, pfc_builder and pfc_query.
// An accepted query passes the prefix table reads and the read stage, then the result register;
// one query per cycle while the result is not stalled. After reset the build runs: a clearing
// pass, a prime-power sieve that scans each number and updates the count of each multiple of
// each prime power, then a prefix pass. Queries are stalled until the build is done.
`timescale 1ns / 1ps
`default_nettype none
module prime_factor_count_range_query_unit
  import pfc_pkg::*;
#(
  parameter int unsigned MAX_N = MAX_N_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        query_valid,
  output logic             query_stall,
  input  wire pfc_query_t  query,
  output logic             result_valid,
  input  wire logic        result_stall,
  output pfc_result_t      result
);

  logic                     ready;
  logic                     pre_we;
  logic [$clog2(MAX_N)-1:0] pre_addr;
  logic [TOTAL_W-1:0]       pre_data;

  pfc_builder #(.MAX_N(MAX_N)) u_builder (
    .clk(clk), .rst(rst),
    .pre_we(pre_we), .pre_addr(pre_addr), .pre_data(pre_data), .ready(ready)
  );

  pfc_query #(.MAX_N(MAX_N)) u_query (
    .clk(clk), .rst(rst), .ready(ready),
    .pre_we(pre_we), .pre_addr(pre_addr), .pre_data(pre_data),
    .query_valid(query_valid), .query_stall(query_stall), .query(query),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  // No query enters before the tables are built.
  a_no_early_accept: assert property (@(posedge clk) disable iff (rst)
    (query_valid && !query_stall) |-> ready) else $error("query taken during build");

  // A bad range always reports a zero total.
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.bad_range) |-> (result.factor_total == '0))
    else $error("bad range with nonzero total");

  // Table writes stop once the build is done.
  a_no_write_ready: assert property (@(posedge clk) disable iff (rst)
    ready |-> !pre_we) else $error("table write after build");

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// Testbench for the prime factor count range query unit.
// It predicts each query's result from its own sieve and prefix tables and
// compares the results item by item. It depends on pfc_pkg and the RTL top level.
`timescale 1ns / 1ps
module tb_top;
  import pfc_pkg::*;

  localparam int unsigned NUM_N = MAX_N_DEFAULT;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        query_valid = 1'b0;
  logic        query_stall;
  pfc_query_t  query = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  pfc_result_t result;

  prime_factor_count_range_query_unit u_top (
    .clk(clk), .rst(rst),
    .query_valid(query_valid), .query_stall(query_stall), .query(query),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  always #5 clk = ~clk;

  // Predictor tables: smallest prime factor and saturated prefix counts.
  int unsigned least_factor [NUM_N];
  logic [TOTAL_W-1:0] prefix_count [NUM_N];

  pfc_query_t  pending_queries [$];
  pfc_result_t expected_results [$];
  int unsigned error_count = 0;
  int unsigned checked_count = 0;
  int unsigned sent_total = 0;
  bit          long_hold = 1'b0;

  function automatic void build_prefix_counts();
    int unsigned count_of [NUM_N];
    int unsigned acc;
    for (int i = 0; i < NUM_N; i++) begin
      least_factor[i] = 0;
      count_of[i] = 0;
    end
    for (longint i = 2; i < NUM_N; i++) begin
      if (least_factor[i] == 0) begin
        least_factor[i] = 32'(i);
        for (longint j = i * i; j < NUM_N; j += i) begin
          if (least_factor[j] == 0) least_factor[j] = 32'(i);
        end
      end
    end
    for (int i = 2; i < NUM_N; i++) begin
      count_of[i] = count_of[i / least_factor[i]] + 1;
    end
    acc = 0;
    prefix_count[0] = '0;
    prefix_count[1] = '0;
    for (int i = 2; i < NUM_N; i++) begin
      acc = (acc > 32'(TOTAL_MAX) - count_of[i]) ? 32'(TOTAL_MAX) : acc + count_of[i];
      prefix_count[i] = acc[TOTAL_W-1:0];
    end
  endfunction

  // Expected result of one query; the tables are always built before any accept.
  function automatic pfc_result_t range_factor_total(pfc_query_t q);
    pfc_result_t r;
    r = '0;
    if (q.lower > q.upper) r.bad_range = 1'b1;
    else r.factor_total = prefix_count[q.upper] - prefix_count[q.lower];
    return r;
  endfunction

  function automatic void add_query(logic [15:0] up, logic [15:0] lo);
    pfc_query_t q;
    q.upper = up;
    q.lower = lo;
    pending_queries.insert(pending_queries.size(), q);
  endfunction

  // Input side: note each accepted item and queue its expected result.
  int unsigned send_gap = 0;
  bit          query_taken;
  always @(posedge clk) begin
    query_taken <= query_valid && !query_stall && !rst;
    if (query_valid && !query_stall && !rst) begin
      expected_results.insert(expected_results.size(), range_factor_total(query));
    end
  end

  // Driver: present queued items at the falling edge with random gaps.
  always @(negedge clk) begin
    if (rst) begin
      query_valid <= 1'b0;
    end else if (query_valid && !query_taken) begin
      // Stalled: hold the item.
    end else if (send_gap != 0) begin
      query_valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (pending_queries.size() != 0) begin
      query <= pending_queries.pop_front();
      query_valid <= 1'b1;
      send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
    end else begin
      query_valid <= 1'b0;
    end
  end

  // Receiver stall: random per item, plus one long hold-off.
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  bit          hold_started = 1'b0;
  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (long_hold && !hold_started && hold_left == 0) begin
      hold_left <= 400;
      hold_started <= 1'b1;
      result_stall <= 1'b1;
    end else if (hold_left > 1) begin
      hold_left <= hold_left - 1;
    end else if (hold_left == 1) begin
      hold_left <= 0;
      result_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
      if (result_valid && !result_stall)
        stall_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
    end
  end

  // Monitor: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    pfc_result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: factor_total %0d bad_range %0d",
               result.factor_total, result.bad_range);
        error_count = error_count + 1;
      end else begin
        want = expected_results.pop_front();
        checked_count = checked_count + 1;
        if (want.factor_total !== result.factor_total) begin
          $error("factor_total: expected %0d, actual %0d",
                 want.factor_total, result.factor_total);
          error_count = error_count + 1;
        end
        if (want.bad_range !== result.bad_range) begin
          $error("bad_range: expected %0d, actual %0d",
                 want.bad_range, result.bad_range);
          error_count = error_count + 1;
        end
      end
    end
  end

  // Stimulus: directed corners, then random ranges mostly well ordered.
  initial begin
    logic [15:0] a, b;
    build_prefix_counts();
    add_query(16'd1, 16'd1);
    add_query(16'd2, 16'd1);
    add_query(16'd2, 16'd0);
    add_query(16'd0, 16'd0);
    add_query(16'hFFFF, 16'd0);
    add_query(16'hFFFF, 16'd1);
    add_query(16'hFFFF, 16'hFFFF);
    add_query(16'hFFFF, 16'hFFFE);
    add_query(16'd0, 16'hFFFF);
    add_query(16'd1, 16'd2);
    add_query(16'd100, 16'd99);
    add_query(16'd99, 16'd100);
    add_query(16'd65521, 16'd65520);
    add_query(16'd32768, 16'd32767);
    add_query(16'h5555, 16'hAAAA);
    add_query(16'hAAAA, 16'h5555);
    add_query(16'd1024, 16'd3);
    add_query(16'd1000, 16'd1000);
    for (int n = 0; n < 1800; n++) begin
      a = 16'($urandom);
      b = 16'($urandom);
      case ($urandom_range(0, 9))
        0: add_query(a, b);
        1: add_query(a, a);
        2: add_query({8'd0, a[7:0]}, {8'd0, b[7:0]});
        default: begin
          if (a < b) add_query(b, a);
          else add_query(a, b);
        end
      endcase
    end
    sent_total = pending_queries.size();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    wait (query_valid && !query_stall);
    repeat (40) @(posedge clk);
    long_hold = 1'b1;
  end

  // End of run: wait until every item has been checked, then report.
  initial begin
    wait (sent_total != 0 && checked_count == sent_total);
    repeat (20) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
